// ----- hdl/upwind_2d_convection_stencil_defines.svh -----
// Assertion macros used by the checker file of the upwind convection stencil.
`ifndef UPWIND_2D_CONVECTION_STENCIL_DEFINES_SVH
`define UPWIND_2D_CONVECTION_STENCIL_DEFINES_SVH

// A property checked on every rising clock edge outside reset.
`define UCS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ucs checker: property violated");

// A property that must also hold while reset is applied.
`define UCS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("ucs checker: property violated");

`endif

// ----- hdl/ucs_pkg.sv -----
// Types and constants shared by the upwind convection stencil modules.
`timescale 1ns / 1ps

package ucs_pkg;

    localparam int VAL_W     = 32;  // Q16.16 velocity word
    localparam int DIFF_W    = 33;  // exact difference of two words
    localparam int PROD_W    = 65;  // p times difference, Q33.32
    localparam int SUM_W     = 51;  // old value minus two shifted terms
    localparam int SIZE_W    = 9;   // grid_width and grid_height registers
    localparam int COUR_W    = 16;  // courant_ratio register, Q0.16
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int PIPE_DEPTH = 5;  // register stages from input beat to output beat

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COURANT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_VALUE  = 2'd3;

    localparam logic [SIZE_W-1:0] RST_GRID_WIDTH  = 9'd201;
    localparam logic [SIZE_W-1:0] RST_GRID_HEIGHT = 9'd201;
    localparam logic [COUR_W-1:0] RST_COURANT     = 16'd13107;
    localparam logic [VAL_W-1:0]  RST_EDGE_VALUE  = 32'h0001_0000;

    typedef struct packed {
        logic [SIZE_W-1:0] grid_width;
        logic [SIZE_W-1:0] grid_height;
        logic [COUR_W-1:0] courant_ratio;
        logic [VAL_W-1:0]  edge_value;
    } t_cfg;

    // One cell with its neighbourhood, as handed from the window to the arithmetic.
    typedef struct packed {
        logic [VAL_W-1:0] u;
        logic [VAL_W-1:0] v;
        logic [VAL_W-1:0] left_u;
        logic [VAL_W-1:0] left_v;
        logic [VAL_W-1:0] up_u;
        logic [VAL_W-1:0] up_v;
        logic             boundary;
        logic             last;
    } t_cell;

endpackage

// ----- hdl/ucs_window.sv -----
// Raster position counters, line store and left neighbour for the stencil.
`timescale 1ns / 1ps

module ucs_window #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ucs_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [ucs_pkg::VAL_W-1:0] i_u,
    input  logic [ucs_pkg::VAL_W-1:0] i_v,
    output logic          o_valid,
    input  logic          i_ready,
    output ucs_pkg::t_cell o_cell
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int LW = ((CW > ucs_pkg::SIZE_W) ? CW : ucs_pkg::SIZE_W) + 1;
    localparam int LH = ((RW > ucs_pkg::SIZE_W) ? RW : ucs_pkg::SIZE_W) + 1;
    localparam int VW = ucs_pkg::VAL_W;

    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [VW-1:0]     r_left_u;
    logic [VW-1:0]     r_left_v;
    logic [2*VW-1:0]   r_line [MAX_WIDTH];
    logic [2*VW-1:0]   r_up;
    logic              r_valid;
    ucs_pkg::t_cell    r_cell;
    ucs_pkg::t_cell    n_cell;

    logic [LW-1:0] w_size;
    logic [LH-1:0] h_size;
    logic          last_col;
    logic          last_row;
    logic          enable;
    logic          accept;

    // Sizes outside the legal range are used clamped.
    always_comb begin
        w_size = LW'(i_cfg.grid_width);
        if (w_size < LW'(3)) begin
            w_size = LW'(3);
        end else if (w_size > LW'(MAX_WIDTH)) begin
            w_size = LW'(MAX_WIDTH);
        end
        h_size = LH'(i_cfg.grid_height);
        if (h_size < LH'(3)) begin
            h_size = LH'(3);
        end else if (h_size > LH'(MAX_HEIGHT)) begin
            h_size = LH'(MAX_HEIGHT);
        end
    end

    assign last_col = LW'(r_col) >= (w_size - LW'(1));
    assign last_row = LH'(r_row) >= (h_size - LH'(1));

    assign enable  = !r_valid || i_ready;
    assign o_ready = enable;
    assign accept  = i_valid && enable;

    always_comb begin
        n_cell          = r_cell;
        n_cell.u        = i_u;
        n_cell.v        = i_v;
        n_cell.left_u   = r_left_u;
        n_cell.left_v   = r_left_v;
        n_cell.boundary = (r_row == '0) || (r_col == '0) || last_row || last_col;
        n_cell.last     = last_col && last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_left_u <= '0;
            r_left_v <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (enable) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_left_u <= i_u;
                r_left_v <= i_v;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : RW'(r_row + 1'b1);
                end else begin
                    r_col <= CW'(r_col + 1'b1);
                end
            end
        end
    end

    // The read returns the entry from the previous row before this beat replaces it.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up          <= r_line[r_col];
            r_line[r_col] <= {i_v, i_u};
            r_cell        <= n_cell;
        end
    end

    always_comb begin
        o_cell      = r_cell;
        o_cell.up_u = r_up[VW-1:0];
        o_cell.up_v = r_up[2*VW-1:VW];
    end

    assign o_valid = r_valid;

endmodule

// ----- hdl/ucs_arith.sv -----
// Four-stage fixed-point upwind update with saturation and boundary select.
`timescale 1ns / 1ps

module ucs_arith (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ucs_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  ucs_pkg::t_cell i_cell,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [ucs_pkg::VAL_W-1:0] o_u,
    output logic [ucs_pkg::VAL_W-1:0] o_v,
    output logic           o_last
);

    localparam int VW = ucs_pkg::VAL_W;
    localparam int DW = ucs_pkg::DIFF_W;
    localparam int PW = ucs_pkg::PROD_W;
    localparam int SW = ucs_pkg::SUM_W;
    localparam int CR = ucs_pkg::COUR_W;
    localparam int MW = VW + CR + 1;
    localparam int TW = PW - 16;

    // Stage two: scaled velocities and differences.
    logic          r_v2;
    logic [VW-1:0] r2_u, r2_v, r2_pu, r2_pv;
    logic [DW-1:0] r2_dul, r2_duu, r2_dvl, r2_dvu;
    logic          r2_bnd, r2_last;
    // Stage three: the four products.
    logic          r_v3;
    logic [VW-1:0] r3_u, r3_v;
    logic [PW-1:0] r3_tul, r3_tuu, r3_tvl, r3_tvu;
    logic          r3_bnd, r3_last;
    // Stage four: unsaturated sums.
    logic          r_v4;
    logic [SW-1:0] r4_nu, r4_nv;
    logic          r4_bnd, r4_last;
    // Stage five: output register.
    logic          r_v5;
    logic [VW-1:0] r5_u, r5_v;
    logic          r5_last;

    logic en2, en3, en4, en5;
    logic [MW-1:0] n_mu, n_mv;
    logic [VW-1:0] n_sat_u, n_sat_v;

    assign en5 = !r_v5 || i_ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign o_ready = en2;

    function automatic logic [DW-1:0] diff(input logic [VW-1:0] a, input logic [VW-1:0] b);
        diff = {a[VW-1], a} - {b[VW-1], b};
    endfunction

    function automatic logic [PW-1:0] smul(input logic [VW-1:0] p, input logic [DW-1:0] d);
        smul = {{(PW-VW){p[VW-1]}}, p} * {{(PW-DW){d[DW-1]}}, d};
    endfunction

    // Floor division by 2^16 is the arithmetic shift, taken as a part-select.
    function automatic logic [SW-1:0] update(input logic [VW-1:0] x,
                                             input logic [PW-1:0] t1,
                                             input logic [PW-1:0] t2);
        update = {{(SW-VW){x[VW-1]}}, x}
               - SW'({{(SW-TW){t1[PW-1]}}, t1[PW-1:16]})
               - SW'({{(SW-TW){t2[PW-1]}}, t2[PW-1:16]});
    endfunction

    function automatic logic [VW-1:0] sat(input logic [SW-1:0] x);
        if (&x[SW-1:VW-1] || ~|x[SW-1:VW-1]) begin
            sat = x[VW-1:0];
        end else if (x[SW-1]) begin
            sat = {1'b1, {(VW-1){1'b0}}};
        end else begin
            sat = {1'b0, {(VW-1){1'b1}}};
        end
    endfunction

    assign n_mu = {{(MW-VW){i_cell.u[VW-1]}}, i_cell.u} * {{(MW-CR){1'b0}}, i_cfg.courant_ratio};
    assign n_mv = {{(MW-VW){i_cell.v[VW-1]}}, i_cell.v} * {{(MW-CR){1'b0}}, i_cfg.courant_ratio};
    assign n_sat_u = r4_bnd ? i_cfg.edge_value : sat(r4_nu);
    assign n_sat_v = r4_bnd ? i_cfg.edge_value : sat(r4_nv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en2) r_v2 <= i_valid;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_u    <= i_cell.u;
            r2_v    <= i_cell.v;
            r2_pu   <= n_mu[VW+15:16];
            r2_pv   <= n_mv[VW+15:16];
            r2_dul  <= diff(i_cell.u, i_cell.left_u);
            r2_duu  <= diff(i_cell.u, i_cell.up_u);
            r2_dvl  <= diff(i_cell.v, i_cell.left_v);
            r2_dvu  <= diff(i_cell.v, i_cell.up_v);
            r2_bnd  <= i_cell.boundary;
            r2_last <= i_cell.last;
        end
        if (en3) begin
            r3_u    <= r2_u;
            r3_v    <= r2_v;
            r3_tul  <= smul(r2_pu, r2_dul);
            r3_tuu  <= smul(r2_pv, r2_duu);
            r3_tvl  <= smul(r2_pu, r2_dvl);
            r3_tvu  <= smul(r2_pv, r2_dvu);
            r3_bnd  <= r2_bnd;
            r3_last <= r2_last;
        end
        if (en4) begin
            r4_nu   <= update(r3_u, r3_tul, r3_tuu);
            r4_nv   <= update(r3_v, r3_tvl, r3_tvu);
            r4_bnd  <= r3_bnd;
            r4_last <= r3_last;
        end
        if (en5) begin
            r5_u    <= n_sat_u;
            r5_v    <= n_sat_v;
            r5_last <= r4_last;
        end
    end

    assign o_valid = r_v5;
    assign o_u     = r5_u;
    assign o_v     = r5_v;
    assign o_last  = r5_last;

endmodule

// ----- hdl/upwind_2d_convection_stencil.sv -----
// Top level of the streaming 2-D upwind convection stencil.
`timescale 1ns / 1ps

// This block takes one grid cell per beat in raster order, each beat carrying the
// cell's old velocity pair, and returns one beat per cell with the new pair from the
// first-order upwind rule, new = old - u*c*(old - left) - v*c*(old - up), computed in
// signed Q16.16 and saturated. Cells on any of the four grid edges return edge_value
// for both components, and tlast marks the final cell of the grid. It sustains one
// cell per clock cycle while m_axis_tready is held high: the line store is a single
// memory of MAX_WIDTH entries that is read and written at the same column on every
// accepted beat, and that one access per cycle sets the rate. A result passes
// through the window register and the scaling and differences, products, sums
// and saturation registers before it leaves. Each stage holds its contents under
// back-pressure, so the input keeps accepting beats as long as some stage ahead
// is empty. The line store needs no clearing after reset: the first row of every
// pass is boundary, so its reads are discarded. Write configuration only while no
// cells are in flight; the position counters are not reset by a write.

module upwind_2d_convection_stencil #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [ucs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ucs_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] u_old, [63:32] v_old
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] u_next, [63:32] v_next
    output logic        m_axis_tlast    // grid_done
);

    localparam int VW = ucs_pkg::VAL_W;

    ucs_pkg::t_cfg  r_cfg;
    ucs_pkg::t_cell win_cell;
    logic           win_valid;
    logic           arith_ready;
    logic [VW-1:0]  out_u;
    logic [VW-1:0]  out_v;

    // Configuration registers; writes to an index outside the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_width    <= ucs_pkg::RST_GRID_WIDTH;
            r_cfg.grid_height   <= ucs_pkg::RST_GRID_HEIGHT;
            r_cfg.courant_ratio <= ucs_pkg::RST_COURANT;
            r_cfg.edge_value    <= ucs_pkg::RST_EDGE_VALUE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ucs_pkg::CFG_GRID_WIDTH: begin
                    r_cfg.grid_width <= i_cfg_data[ucs_pkg::SIZE_W-1:0];
                end
                ucs_pkg::CFG_GRID_HEIGHT: begin
                    r_cfg.grid_height <= i_cfg_data[ucs_pkg::SIZE_W-1:0];
                end
                ucs_pkg::CFG_COURANT: begin
                    r_cfg.courant_ratio <= i_cfg_data[ucs_pkg::COUR_W-1:0];
                end
                ucs_pkg::CFG_EDGE_VALUE: begin
                    r_cfg.edge_value <= i_cfg_data[VW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The window forms each cell's neighbourhood and flags the grid edges.
    ucs_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_u     (s_axis_tdata[VW-1:0]),
        .i_v     (s_axis_tdata[2*VW-1:VW]),
        .o_valid (win_valid),
        .i_ready (arith_ready),
        .o_cell  (win_cell)
    );

    // The arithmetic pipeline ends in the output register seen on the master side.
    ucs_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (win_valid),
        .o_ready (arith_ready),
        .i_cell  (win_cell),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_u     (out_u),
        .o_v     (out_v),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_v, out_u};

endmodule

// ----- hdl/ucs_checker.sv -----
// Port-level checker for the upwind convection stencil, bound to the top level.
`timescale 1ns / 1ps
`include "upwind_2d_convection_stencil_defines.svh"

module ucs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    logic [3:0] r_inflight;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    // Cells accepted whose results have not yet left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + {3'd0, in_beat} - {3'd0, out_beat};
        end
    end

    `UCS_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !m_axis_tvalid)
    `UCS_ASSERT(a_stall_holds, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    `UCS_ASSERT(a_empty_accepts, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready)
    `UCS_ASSERT(a_depth_bound, i_clk, i_rst_n, (r_inflight <= 4'(ucs_pkg::PIPE_DEPTH)) && (!m_axis_tvalid || (r_inflight != 4'd0)))

endmodule

bind upwind_2d_convection_stencil ucs_checker u_ucs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
